/* hw/rtl/aes_pkg.sv */
// AES mode engine package: payload structs, command/status types, S-boxes
// and round functions shared by the controller and datapath.
// No dependencies.
package aes_pkg;

    typedef struct packed {
        logic        restart;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_word_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_word_t;

    localparam logic [1:0] MODE_CBC_ENC = 2'd0;
    localparam logic [1:0] MODE_CBC_DEC = 2'd1;
    localparam logic [1:0] MODE_CTR     = 2'd2;

    localparam logic [1:0] KSZ_128 = 2'd0;
    localparam logic [1:0] KSZ_192 = 2'd1;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_KSZ  = 3'd1;
    localparam logic [2:0] REG_KEY0 = 3'd2;
    localparam logic [2:0] REG_KEY1 = 3'd3;
    localparam logic [2:0] REG_KEY2 = 3'd4;
    localparam logic [2:0] REG_KEY3 = 3'd5;
    localparam logic [2:0] REG_IVH  = 3'd6;
    localparam logic [2:0] REG_IVL  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_INIT,
        ST_ROUND,
        ST_DONE,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;       // capture input word
        logic       reload_iv;  // chain from IV registers
        logic       kexp_start; // begin key schedule
        logic       kexp_step;  // one schedule word
        logic       init;       // initial key add
        logic       round;      // one cipher round
        logic       finish;     // form result, update chain
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       kexp_done;
        logic       last_round;
    } dp_sts_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // GF(2^8) multiply, shift-and-add over the bits of b.
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) r = r ^ x;
            x = xt(x);
        end
        return r;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    // byte k of a 128-bit word, byte 0 most significant
    function automatic logic [7:0] byte_of(input logic [127:0] s, input int k);
        return s[127-8*k -: 8];
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[i+4*c] = sbox(byte_of(s, i + 4*((c+i)%4)));
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        for (int k = 0; k < 16; k++) r[127-8*k -: 8] = t[k];
        return r;
    endfunction

    // inverse shift and substitute; the key add and inverse mix follow
    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                r[127-8*(i+4*((c+i)%4)) -: 8] = inv_sbox(byte_of(s, i + 4*c));
        return r;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
        begin
            a0 = byte_of(s, 4*c); a1 = byte_of(s, 4*c+1);
            a2 = byte_of(s, 4*c+2); a3 = byte_of(s, 4*c+3);
            r[127-32*c -: 8]    = gmul(a0,8'd14)^gmul(a1,8'd11)^gmul(a2,8'd13)^gmul(a3,8'd9);
            r[119-32*c -: 8]    = gmul(a0,8'd9)^gmul(a1,8'd14)^gmul(a2,8'd11)^gmul(a3,8'd13);
            r[111-32*c -: 8]    = gmul(a0,8'd13)^gmul(a1,8'd9)^gmul(a2,8'd14)^gmul(a3,8'd11);
            r[103-32*c -: 8]    = gmul(a0,8'd11)^gmul(a1,8'd13)^gmul(a2,8'd9)^gmul(a3,8'd14);
        end
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

/* hw/rtl/aes_cbc_ctr_mode_engine.sv */
// AES CBC/CTR mode engine: one 128-bit word in, one 128-bit word out.
// A restart word first runs the Nk-word key schedule; each word then takes
// Nr rounds through the single round unit before its result is presented.
// A new word is taken only after the previous result has left the output.
// Reset: mode, key, IV and chain cleared; round keys undefined until restart.
module aes_cbc_ctr_mode_engine #(
    parameter int BLOCK_BYTES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  aes_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output aes_pkg::out_word_t out_data
);
    import aes_pkg::*;

    // register data width: half a block
    localparam int CFG_BITS = 8 * BLOCK_BYTES / 2;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Controller: accept, schedule, round loop, present result.
    aes_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_restart (in_data.restart),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Datapath: registers, key memory, round unit, chain.
    aes_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data[CFG_BITS-1:0]),
        .in_word   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_word  (out_data)
    );
endmodule

/* hw/rtl/aes_ctrl.sv */
// AES mode engine controller: sequences key schedule, rounds and output.
// Depends on aes_pkg.
module aes_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_restart,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  aes_pkg::dp_sts_t sts,
    output aes_pkg::dp_cmd_t cmd
);
    import aes_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = in_restart ? ST_KEXP : ST_INIT;
            ST_KEXP:  if (sts.kexp_done) state_next = ST_INIT;
            ST_INIT:  state_next = ST_ROUND;
            ST_ROUND: if (sts.last_round) state_next = ST_DONE;
            ST_DONE:  state_next = ST_OUT;
            ST_OUT:   if (!out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.load       = in_valid;
                cmd.reload_iv  = in_valid & in_restart;
                cmd.kexp_start = in_valid & in_restart;
            end
            ST_KEXP:  cmd.kexp_step = 1'b1;
            ST_INIT:  cmd.init = 1'b1;
            ST_ROUND: cmd.round = 1'b1;
            ST_DONE:  cmd.finish = 1'b1;
            ST_OUT:   out_valid = 1'b1;
            default:  cmd = '0;
        endcase
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |=> out_valid)
        else $error("finish not followed by result");
endmodule

/* hw/rtl/aes_dp.sv */
// AES mode engine datapath: config registers, key schedule memory,
// iterative round unit and chain register. Depends on aes_pkg.
module aes_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    input  aes_pkg::in_word_t in_word,
    input  aes_pkg::dp_cmd_t  cmd,
    output aes_pkg::dp_sts_t  sts,
    output aes_pkg::out_word_t out_word
);
    import aes_pkg::*;

    logic [1:0]   mode_reg, ksz_reg;
    logic [63:0]  key_reg [4];
    logic [127:0] iv_reg;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] blk_reg;
    logic [127:0] st_reg, st_next;
    logic [127:0] res_reg;
    logic [3:0]   nr_reg;
    logic [3:0]   rnd_reg;
    logic [31:0]  w_reg [8];
    logic [5:0]   wi_reg;
    logic [2:0]   kph_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   nk_reg;
    logic [5:0]   total_reg;
    logic [127:0] rk_mem [15];
    logic [127:0] rk_q;
    logic [127:0] rkw_reg;
    logic [3:0]   rd_addr;
    logic         dec;

    assign dec = (mode_reg == MODE_CBC_DEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CBC_ENC;
            ksz_reg  <= KSZ_128;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            iv_reg   <= '0;
            chain_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE: mode_reg <= cfg_data[1:0];
                    REG_KSZ:  ksz_reg  <= cfg_data[1:0];
                    REG_KEY0: key_reg[0] <= cfg_data;
                    REG_KEY1: key_reg[1] <= cfg_data;
                    REG_KEY2: key_reg[2] <= cfg_data;
                    REG_KEY3: key_reg[3] <= cfg_data;
                    REG_IVH:  iv_reg[127:64] <= cfg_data;
                    REG_IVL:  iv_reg[63:0]   <= cfg_data;
                    default:  mode_reg <= mode_reg;
                endcase
            end
            chain_reg <= chain_next;
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (cmd.reload_iv) chain_next = iv_reg;
        else if (cmd.finish)
        begin
            case (mode_reg)
                MODE_CBC_ENC: chain_next = st_reg;
                MODE_CBC_DEC: chain_next = blk_reg;
                default:      chain_next = chain_reg + 128'd1;
            endcase
        end
    end

    // Key schedule: one 32-bit word per cycle into an 8-word window; every
    // fourth word writes a 128-bit round key. kph_reg tracks the word index
    // modulo Nk.
    logic [31:0] t_w, new_w;
    logic [2:0]  ph;
    always_comb
    begin
        ph  = 3'((wi_reg - 6'd1) % 8);
        t_w = w_reg[ph];
        if (kph_reg == 3'd0)
            t_w = sub_word({t_w[23:0], t_w[31:24]}) ^ {rcon_reg, 24'h0};
        else if (nk_reg == 4'd8 && kph_reg == 3'd4)
            t_w = sub_word(t_w);
        new_w = w_reg[3'(wi_reg % 8)] ^ t_w;
        if (nk_reg == 4'd6) new_w = w_reg[3'((wi_reg + 6'd2) % 8)] ^ t_w;
        if (nk_reg == 4'd4) new_w = w_reg[3'((wi_reg + 6'd4) % 8)] ^ t_w;
    end

    // window kept as ring: w[i] stored at slot i mod 8
    always_ff @(posedge clk)
    begin
        if (cmd.kexp_start)
        begin
            for (int i = 0; i < 8; i++)
                w_reg[i] <= i[0] ? key_reg[i>>1][31:0] : key_reg[i>>1][63:32];
            nk_reg    <= (ksz_reg == KSZ_128) ? 4'd4 : (ksz_reg == KSZ_192) ? 4'd6 : 4'd8;
            total_reg <= (ksz_reg == KSZ_128) ? 6'd44 : (ksz_reg == KSZ_192) ? 6'd52 : 6'd60;
            wi_reg    <= 6'd0;
            kph_reg   <= 3'd0;
            rcon_reg  <= 8'h01;
        end
        else if (cmd.kexp_step)
        begin
            if (wi_reg >= 6'(nk_reg))
            begin
                w_reg[3'(wi_reg % 8)] <= new_w;
                rkw_reg <= {rkw_reg[95:0], new_w};
                if (kph_reg == 3'd0) rcon_reg <= xt(rcon_reg);
            end
            else
                rkw_reg <= {rkw_reg[95:0], w_reg[3'(wi_reg % 8)]};
            wi_reg  <= wi_reg + 6'd1;
            kph_reg <= ({1'b0, kph_reg} == nk_reg - 4'd1) ? 3'd0 : kph_reg + 3'd1;
        end
    end

    // write completed round key in the cycle after its fourth word
    logic kwr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) kwr_reg <= 1'b0;
        else        kwr_reg <= cmd.kexp_step && (wi_reg[1:0] == 2'd3);
    end

    logic [3:0] kwa_reg;
    always_ff @(posedge clk)
    begin
        kwa_reg <= 4'(wi_reg >> 2);
        if (kwr_reg) rk_mem[kwa_reg] <= rkw_reg;
        rk_q <= rk_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.kexp_start)
            nr_reg <= (ksz_reg == KSZ_128) ? 4'd10 : (ksz_reg == KSZ_192) ? 4'd12 : 4'd14;
    end

    // the kexp_done flag waits for the last write to land
    assign sts.kexp_done  = (wi_reg == total_reg + 6'd1);
    assign sts.last_round = (rnd_reg == nr_reg);

    // Round key read address: set in the cycle before the key is used, as rk_q is registered.
    always_comb
    begin
        if (cmd.kexp_step || cmd.load) rd_addr = dec ? nr_reg : 4'd0;
        else if (cmd.init)             rd_addr = dec ? nr_reg - 4'd1 : 4'd1;
        else                           rd_addr = dec ? nr_reg - rnd_reg - 4'd1 : rnd_reg + 4'd1;
    end

    logic [127:0] dsub;
    always_comb
    begin
        st_next = st_reg;
        dsub    = dec_sub(st_reg) ^ rk_q;
        if (cmd.init)
        begin
            case (mode_reg)
                MODE_CBC_ENC: st_next = blk_reg ^ chain_reg ^ rk_q;
                MODE_CBC_DEC: st_next = blk_reg ^ rk_q;
                default:      st_next = chain_reg ^ rk_q;
            endcase
        end
        else if (cmd.round)
        begin
            if (dec) st_next = (rnd_reg == nr_reg) ? dsub : inv_mix(dsub);
            else     st_next = enc_round(st_reg, rnd_reg == nr_reg) ^ rk_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) blk_reg <= {in_word.block_high, in_word.block_low};
        st_reg <= st_next;
        if (cmd.init) rnd_reg <= 4'd1;
        else if (cmd.round) rnd_reg <= rnd_reg + 4'd1;
        if (cmd.finish)
        begin
            case (mode_reg)
                MODE_CBC_ENC: res_reg <= st_reg;
                MODE_CBC_DEC: res_reg <= st_reg ^ chain_reg;
                default:      res_reg <= st_reg ^ blk_reg;
            endcase
        end
    end

    assign out_word.result_high = res_reg[127:64];
    assign out_word.result_low  = res_reg[63:0];
endmodule

/* tb/sv/aes_cbc_ctr_mode_engine_tb.sv */
// Self-checking testbench for the AES CBC/CTR mode engine: directed and random
// words, checked against an AES predictor kept inside the testbench.
// Depends on aes_pkg (payload structs, mode and register codes) and the engine RTL.
`timescale 1ns / 1ps

module aes_cbc_ctr_mode_engine_tb;
    import aes_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    // longest key schedule plus the longest cipher pass, with margin
    localparam int SETTLE_CYCLES = 120;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [2:0] cfg_index;
    logic [63:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;

    aes_cbc_ctr_mode_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // Clock: 4 ns period
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the registers, the chain and the key
    // schedule. Updated only when a word is accepted or a register written.
    // ------------------------------------------------------------------
    bit [7:0]   fwd_sub [256];
    bit [7:0]   inv_sub [256];
    bit [1:0]   mode_reg;
    bit [1:0]   ksize_reg;
    bit [63:0]  key_reg [4];
    bit [63:0]  ivh_reg;
    bit [63:0]  ivl_reg;
    bit [127:0] chain;
    bit [127:0] sched [15];
    int         num_rounds;

    out_word_t  pending_results [$];
    int         mismatches;
    int         cycles;
    int         send_idle_pct;
    int         stall_pct;

    function automatic bit [7:0] xtime(input bit [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic bit [7:0] gf_mul(input bit [7:0] a, input bit [7:0] b);
        bit [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) acc ^= a;
            a = xtime(a);
        end
        return acc;
    endfunction

    // Build the S-box from first principles: inverse in GF(2^8), then affine map.
    function automatic void build_sub_tables();
        bit [7:0] inv;
        bit [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h01;
            // x^254 is the multiplicative inverse, and maps 0 to 0
            for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
            if (x == 0) inv = 8'h00;
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[x] = s;
            inv_sub[s] = 8'(x);
        end
    endfunction

    function automatic bit [7:0] get_byte(input bit [127:0] s, input int k);
        return s[127-8*k -: 8];
    endfunction

    function automatic bit [31:0] sub_bytes32(input bit [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    // Key schedule from the shadow key registers; latches the round count.
    function automatic void expand_schedule();
        bit [31:0] w [60];
        bit [31:0] t;
        bit [7:0]  rc;
        int        nk;
        int        total;
        nk = (ksize_reg == KSZ_128) ? 4 : (ksize_reg == KSZ_192) ? 6 : 8;
        num_rounds = nk + 6;
        total = 4 * (num_rounds + 1);
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            w[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        for (int i = nk; i < total; i++)
        begin
            t = w[i-1];
            if (i % nk == 0)
            begin
                t = sub_bytes32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = xtime(rc);
            end
            else if (nk > 6 && i % nk == 4)
                t = sub_bytes32(t);
            w[i] = w[i-nk] ^ t;
        end
        for (int i = 0; i < total; i++)
            sched[i >> 2][127-32*(i % 4) -: 32] = w[i];
    endfunction

    function automatic bit [127:0] aes_forward(input bit [127:0] s);
        bit [127:0] t;
        bit [7:0]   a0, a1, a2, a3, al;
        s ^= sched[0];
        for (int r = 1; r <= num_rounds; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[127-8*(i+4*c) -: 8] = fwd_sub[get_byte(s, i + 4*((c+i)%4))];
            if (r != num_rounds)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = get_byte(t, 4*c);   a1 = get_byte(t, 4*c+1);
                    a2 = get_byte(t, 4*c+2); a3 = get_byte(t, 4*c+3);
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                    t[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                    t[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                    t[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
                end
            end
            s = t ^ sched[r];
        end
        return s;
    endfunction

    function automatic bit [127:0] aes_inverse(input bit [127:0] s);
        bit [127:0] t;
        bit [7:0]   a0, a1, a2, a3;
        s ^= sched[num_rounds];
        for (int r = num_rounds - 1; r >= 0; r--)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[127-8*(i+4*((c+i)%4)) -: 8] = inv_sub[get_byte(s, i + 4*c)];
            s = t ^ sched[r];
            if (r != 0)
            begin
                t = s;
                for (int c = 0; c < 4; c++)
                begin
                    a0 = get_byte(t, 4*c);   a1 = get_byte(t, 4*c+1);
                    a2 = get_byte(t, 4*c+2); a3 = get_byte(t, 4*c+3);
                    s[127-32*c -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11)
                                     ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
                    s[119-32*c -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14)
                                     ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
                    s[111-32*c -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)
                                     ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
                    s[103-32*c -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13)
                                     ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
                end
            end
        end
        return s;
    endfunction

    // Advance the shadow chain by one accepted word and return its result block.
    function automatic bit [127:0] chain_block(input bit rs, input bit [127:0] blk);
        bit [127:0] res;
        if (rs)
        begin
            chain = {ivh_reg, ivl_reg};
            expand_schedule();
        end
        if (mode_reg == MODE_CBC_ENC)
        begin
            res = aes_forward(blk ^ chain);
            chain = res;
        end
        else if (mode_reg == MODE_CBC_DEC)
        begin
            res = aes_inverse(blk) ^ chain;
            chain = blk;
        end
        else
        begin
            // CTR, also taken by the unused mode code
            res = blk ^ aes_forward(chain);
            chain = chain + 128'd1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input bit [63:0] got, input bit [63:0] exp);
        $display("[%0t] %s: got %h expected %h", $realtime, what, got, exp);
        mismatches++;
    endtask

    // Write one register; the shadow copy follows at once since the block is idle.
    task automatic write_reg(input logic [2:0] idx, input bit [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_MODE: mode_reg  = val[1:0];
            REG_KSZ:  ksize_reg = val[1:0];
            REG_KEY0: key_reg[0] = val;
            REG_KEY1: key_reg[1] = val;
            REG_KEY2: key_reg[2] = val;
            REG_KEY3: key_reg[3] = val;
            REG_IVH:  ivh_reg = val;
            REG_IVL:  ivl_reg = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Send one word: random idle first, then hold valid and payload until accepted.
    task automatic send_word(input bit rs, input bit [127:0] blk);
        out_word_t exp;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{restart: rs, block_high: blk[127:64], block_low: blk[63:0]};
        do
            @(posedge clk);
        while (in_stall);
        exp = chain_block(rs, blk);
        pending_results.push_back(exp);
    endtask

    // Drop valid and wait until every expected word is back, plus settling time.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit [127:0] rand_block();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {rand64(), rand64()};
        endcase
    endfunction

    task automatic load_key(input bit [1:0] ks, input bit [63:0] k0, input bit [63:0] k1,
                            input bit [63:0] k2, input bit [63:0] k3);
        write_reg(REG_KSZ, {62'h0, ks});
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
    endtask

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        out_word_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result_high", out_data.result_high, 64'h0);
            end
            else
            begin
                exp = pending_results.pop_front();
                if (out_data.result_high !== exp.result_high)
                    report_mismatch("result_high", out_data.result_high, exp.result_high);
                if (out_data.result_low !== exp.result_low)
                    report_mismatch("result_low", out_data.result_low, exp.result_low);
            end
        end
    end

    // Receiver back-pressure, randomized per cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every mode on a 128-bit key, extreme blocks, and the unused mode code.
    task automatic test_modes();
        load_key(KSZ_128, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '0, '0);
        write_reg(REG_IVH, 64'h0001020304050607);
        write_reg(REG_IVL, 64'h08090a0b0c0d0e0f);
        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_MODE, 64'(m));
            send_word(1'b1, '0);
            send_word(1'b0, '1);
            send_word(1'b0, {rand64(), rand64()});
            drain();
        end
    endtask

    // 192 and 256-bit keys, plus the unused key size code taken as 256.
    task automatic test_key_sizes();
        write_reg(REG_MODE, {62'h0, MODE_CBC_ENC});
        for (int ks = 1; ks < 4; ks++)
        begin
            load_key(2'(ks), '1, '0, '1, rand64());
            send_word(1'b1, {rand64(), rand64()});
            send_word(1'b0, {rand64(), rand64()});
            drain();
        end
    endtask

    // New key registers without restart keep the old schedule until restart.
    task automatic test_key_hold();
        write_reg(REG_MODE, {62'h0, MODE_CBC_DEC});
        load_key(KSZ_128, rand64(), rand64(), rand64(), rand64());
        send_word(1'b1, {rand64(), rand64()});
        drain();
        load_key(KSZ_192, rand64(), rand64(), rand64(), rand64());
        send_word(1'b0, {rand64(), rand64()});
        send_word(1'b1, {rand64(), rand64()});
        drain();
    endtask

    // Counter reaching the top of the low half, and full 128-bit wrap to zero.
    task automatic test_counter_wrap();
        write_reg(REG_MODE, {62'h0, MODE_CTR});
        write_reg(REG_IVH, 64'h00000000ffffffff);
        write_reg(REG_IVL, 64'hfffffffffffffffe);
        send_word(1'b1, rand_block());
        send_word(1'b0, rand_block());
        drain();
        write_reg(REG_IVH, '1);
        write_reg(REG_IVL, '1);
        send_word(1'b1, '0);
        send_word(1'b0, '0);
        drain();
    endtask

    // Random segments: fresh settings, then a restart word and a stream of words.
    task automatic test_random(input int idle, input int stall, input int segments);
        int words;
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int s = 0; s < segments; s++)
        begin
            write_reg(REG_MODE, {62'h0, 2'($urandom_range(3))});
            // favor short keys so most words run fast
            load_key(($urandom_range(3) == 0) ? 2'($urandom_range(3)) : KSZ_128,
                     rand64(), rand64(), rand64(), rand64());
            write_reg(REG_IVH, ($urandom_range(4) == 0) ? '1 : rand64());
            write_reg(REG_IVL, ($urandom_range(3) == 0) ? 64'hffff_ffff_ffff_fff0 : rand64());
            words = $urandom_range(15, 35);
            send_word(1'b1, rand_block());
            for (int i = 1; i < words; i++)
                send_word($urandom_range(9) == 0, rand_block());
            drain();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        mismatches    = 0;
        cycles        = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        mode_reg      = MODE_CBC_ENC;
        ksize_reg     = KSZ_128;
        key_reg       = '{default: '0};
        ivh_reg       = '0;
        ivl_reg       = '0;
        chain         = '0;
        num_rounds    = 10;
        build_sub_tables();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_modes();
        test_key_sizes();
        test_key_hold();
        test_counter_wrap();
        // no idling, sender idle, receiver stalling, then both
        test_random(0, 0, 4);
        test_random(45, 0, 4);
        test_random(0, 45, 4);
        test_random(16, 16, 4);

        drain();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
